// ----- sv/fermion_hop_sign_and_rank_assert.svh -----
// ---------------------------------------------------------------------------
// fermion_hop_sign_and_rank assertion macros
// Short forms for the clocked checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef FERMION_HOP_SIGN_AND_RANK_ASSERT_SVH
`define FERMION_HOP_SIGN_AND_RANK_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FHSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define FHSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/fhsr_pkg.sv -----
// ---------------------------------------------------------------------------
// fhsr_pkg
// Shared widths, codes and controller/datapath types of the hopping block.
// ---------------------------------------------------------------------------
package fhsr_pkg;

	localparam int SITE_W    = 5;   // site numbers, counts, table columns
	localparam int BIN_W     = 29;  // binomial values and basis indexes
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SITE_COUNT     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT = 1'b1;

	localparam logic [SITE_W-1:0] SITE_COUNT_RST     = 5'd8;
	localparam logic [SITE_W-1:0] PARTICLE_COUNT_RST = 5'd4;

	localparam logic signed [1:0] SIGN_ZERO = 2'sb00;
	localparam logic signed [1:0] SIGN_POS  = 2'sb01;
	localparam logic signed [1:0] SIGN_NEG  = 2'sb11;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_FILL,
		OP_ACCEPT,
		OP_SIZE,
		OP_CHECK,
		OP_UNRANK,
		OP_DECIDE,
		OP_RANK,
		OP_OUTPUT
	} dp_op_t;

	// datapath status back to the controller
	typedef struct packed {
		logic fill_last;
		logic idx_err;
		logic no_sites;
		logic unrank_last;
		logic hop;
		logic rank_last;
	} dp_stat_t;

endpackage

// ----- sv/fhsr_if.sv -----
// ---------------------------------------------------------------------------
// fhsr channel interfaces
// Valid/ready channels for the operator words in and the result words out.
// ---------------------------------------------------------------------------
interface fhsr_in_if;
	logic                             valid;
	logic                             ready;
	logic [fhsr_pkg::SITE_W-1:0]      source_site;
	logic [fhsr_pkg::SITE_W-1:0]      target_site;
	logic [fhsr_pkg::BIN_W-1:0]       state_index;

	modport source (output valid, source_site, target_site, state_index, input ready);
	modport sink   (input valid, source_site, target_site, state_index, output ready);
endinterface

interface fhsr_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [1:0]                sign;
	logic [fhsr_pkg::BIN_W-1:0]       result_index;
	logic                             index_error;

	modport source (output valid, sign, result_index, index_error, input ready);
	modport sink   (input valid, sign, result_index, index_error, output ready);
endinterface

// ----- sv/fhsr_dp.sv -----
// ---------------------------------------------------------------------------
// fhsr_dp
// Datapath: config registers, binomial table, unrank/rank registers, output.
// ---------------------------------------------------------------------------
module fhsr_dp #(
	parameter int MAX_SITES = 31
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [fhsr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fhsr_pkg::SITE_W-1:0]       cfg_data,
	input  fhsr_pkg::dp_op_t                  op,
	output fhsr_pkg::dp_stat_t                stat,
	input  logic [fhsr_pkg::SITE_W-1:0]       source_site,
	input  logic [fhsr_pkg::SITE_W-1:0]       target_site,
	input  logic [fhsr_pkg::BIN_W-1:0]        state_index,
	output logic signed [1:0]                 sign,
	output logic [fhsr_pkg::BIN_W-1:0]        result_index,
	output logic                              index_error
);

	localparam int RowW  = $clog2(MAX_SITES + 1);
	localparam int ColW  = fhsr_pkg::SITE_W;
	localparam int Cols  = 1 << ColW;
	localparam int Depth = (MAX_SITES + 1) * Cols;
	localparam int W     = MAX_SITES;
	localparam int BinW  = fhsr_pkg::BIN_W;

	typedef enum logic [1:0] {
		KIND_ERR,
		KIND_ZERO,
		KIND_SAME,
		KIND_HOP
	} kind_t;

	logic [ColW-1:0] site_q, part_q;

	// binomial table, row n column k holds C(n, k)
	logic [BinW-1:0] mem [Depth];
	logic [BinW-1:0] prow_q [Cols];
	logic [BinW-1:0] next_row [Cols];
	logic [RowW-1:0] fill_row_q;
	logic [ColW-1:0] fill_col_q;
	logic [BinW-1:0] rd_q;
	logic [RowW-1:0] rd_row;
	logic [ColW-1:0] rd_col;

	logic [ColW-1:0] src_q, dst_q, p_q, k_q, kc_q;
	logic [BinW-1:0] idx_q, size_q, asc_q, acc_q;
	logic [RowW-1:0] s_q, pos_q, cnt_q;
	logic [W-1:0]    w_q, sh_q;
	logic            bitp_q, neg_q;
	kind_t           kind_q;

	logic signed [1:0] sign_q;
	logic [BinW-1:0]   res_q;
	logic              err_q;

	logic [RowW-1:0] s_clamp;
	logic            take;
	logic [W-1:0]    src_oh, dst_oh, nw;
	logic            src_in, dst_in, occ_src, occ_dst, parity;
	kind_t           kind_d;

	assign s_clamp = (site_q > ColW'(MAX_SITES)) ? RowW'(MAX_SITES) : RowW'(site_q);
	assign take    = (k_q != '0) && (rd_q <= asc_q);

	assign src_oh  = W'(1) << src_q;
	assign dst_oh  = W'(1) << dst_q;
	assign src_in  = src_q < ColW'(s_q);
	assign dst_in  = dst_q < ColW'(s_q);
	assign occ_src = |(w_q & src_oh);
	assign occ_dst = |(w_q & dst_oh);
	assign nw      = (w_q | dst_oh) & ~src_oh;
	assign parity  = (^(w_q & (src_oh - W'(1)))) ^ (^(w_q & (dst_oh - W'(1))))
		^ (src_q < dst_q);

	always_comb begin
		if (!src_in || !occ_src) begin
			kind_d = KIND_ZERO;
		end else if (src_q == dst_q) begin
			kind_d = KIND_SAME;
		end else if (!dst_in || occ_dst) begin
			kind_d = KIND_ZERO;
		end else begin
			kind_d = KIND_HOP;
		end
	end

	assign stat.fill_last   = (fill_row_q == RowW'(MAX_SITES)) && (fill_col_q == '1);
	assign stat.idx_err     = idx_q >= rd_q;
	assign stat.no_sites    = s_q == '0;
	assign stat.unrank_last = pos_q == RowW'(1);
	assign stat.hop         = kind_d == KIND_HOP;
	assign stat.rank_last   = cnt_q == s_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			site_q <= fhsr_pkg::SITE_COUNT_RST;
			part_q <= fhsr_pkg::PARTICLE_COUNT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				fhsr_pkg::CFG_SITE_COUNT:     site_q <= cfg_data;
				fhsr_pkg::CFG_PARTICLE_COUNT: part_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next pascal row, one adder per column past column 0
	always_comb begin
		next_row[0] = BinW'(1);
		for (int k = 1; k < Cols; k++) begin
			next_row[k] = prow_q[k] + prow_q[k-1];
		end
	end

	// table fill sweep, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_row_q <= '0;
			fill_col_q <= '0;
			for (int k = 0; k < Cols; k++) begin
				prow_q[k] <= (k == 0) ? BinW'(1) : '0;
			end
		end else if (op == fhsr_pkg::OP_FILL) begin
			fill_col_q <= fill_col_q + ColW'(1);
			if (fill_col_q == '1) begin
				fill_row_q <= fill_row_q + RowW'(1);
				prow_q     <= next_row;
			end
		end
	end

	// table lookup address
	always_comb begin
		rd_row = '0;
		rd_col = '0;
		unique case (op)
			fhsr_pkg::OP_SIZE: begin
				rd_row = s_q;
				rd_col = p_q;
			end
			fhsr_pkg::OP_CHECK: begin
				rd_row = (s_q != '0) ? s_q - RowW'(1) : '0;
				rd_col = p_q;
			end
			fhsr_pkg::OP_UNRANK: begin
				rd_row = (pos_q > RowW'(1)) ? pos_q - RowW'(2) : '0;
				rd_col = take ? k_q - ColW'(1) : k_q;
			end
			fhsr_pkg::OP_DECIDE: begin
				rd_col = ColW'(nw[0]);
			end
			fhsr_pkg::OP_RANK: begin
				rd_row = cnt_q;
				rd_col = kc_q + ColW'(sh_q[0]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (op == fhsr_pkg::OP_FILL) begin
			mem[{fill_row_q, fill_col_q}] <= prow_q[fill_col_q];
		end
		rd_q <= mem[{rd_row, rd_col}];
	end

	// item registers
	always_ff @(posedge clk) begin
		unique case (op)
			fhsr_pkg::OP_ACCEPT: begin
				src_q <= source_site;
				dst_q <= target_site;
				idx_q <= state_index;
				s_q   <= s_clamp;
				p_q   <= part_q;
			end
			fhsr_pkg::OP_CHECK: begin
				size_q <= rd_q;
				asc_q  <= rd_q - BinW'(1) - idx_q;
				pos_q  <= s_q;
				k_q    <= p_q;
				w_q    <= '0;
				kind_q <= KIND_ERR;
			end
			fhsr_pkg::OP_UNRANK: begin
				w_q   <= {w_q[W-2:0], take};
				pos_q <= pos_q - RowW'(1);
				if (take) begin
					asc_q <= asc_q - rd_q;
					k_q   <= k_q - ColW'(1);
				end
			end
			fhsr_pkg::OP_DECIDE: begin
				kind_q <= kind_d;
				neg_q  <= parity;
				sh_q   <= nw >> 1;
				bitp_q <= nw[0];
				kc_q   <= ColW'(nw[0]);
				cnt_q  <= RowW'(1);
				acc_q  <= '0;
			end
			fhsr_pkg::OP_RANK: begin
				if (bitp_q) begin
					acc_q <= acc_q + rd_q;
				end
				sh_q   <= sh_q >> 1;
				bitp_q <= sh_q[0];
				kc_q   <= kc_q + ColW'(sh_q[0]);
				cnt_q  <= cnt_q + RowW'(1);
			end
			fhsr_pkg::OP_OUTPUT: begin
				case (kind_q)
					KIND_ERR: begin
						sign_q <= fhsr_pkg::SIGN_ZERO;
						res_q  <= '0;
						err_q  <= 1'b1;
					end
					KIND_SAME: begin
						sign_q <= fhsr_pkg::SIGN_POS;
						res_q  <= idx_q;
						err_q  <= 1'b0;
					end
					KIND_HOP: begin
						sign_q <= neg_q ? fhsr_pkg::SIGN_NEG : fhsr_pkg::SIGN_POS;
						res_q  <= size_q - BinW'(1) - acc_q;
						err_q  <= 1'b0;
					end
					default: begin
						sign_q <= fhsr_pkg::SIGN_ZERO;
						res_q  <= '0;
						err_q  <= 1'b0;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign sign         = sign_q;
	assign result_index = res_q;
	assign index_error  = err_q;

endmodule

// ----- sv/fhsr_ctrl.sv -----
// ---------------------------------------------------------------------------
// fhsr_ctrl
// Controller: sequences table fill, unrank pass, checks, rank pass, output.
// ---------------------------------------------------------------------------
module fhsr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  fhsr_pkg::dp_stat_t  stat,
	input  logic                item_valid,
	output logic                item_ready,
	output logic                result_valid,
	input  logic                result_ready,
	output fhsr_pkg::dp_op_t    op
);

	typedef enum logic [2:0] {
		ST_FILL,
		ST_IDLE,
		ST_SIZE,
		ST_CHECK,
		ST_UNRANK,
		ST_DECIDE,
		ST_RANK,
		ST_FINAL
	} state_t;

	state_t state_q, state_d;
	logic   ov_q;
	logic   load;

	always_comb begin
		state_d = state_q;
		op      = fhsr_pkg::OP_IDLE;
		load    = 1'b0;
		unique case (state_q)
			ST_FILL: begin
				op = fhsr_pkg::OP_FILL;
				if (stat.fill_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					op      = fhsr_pkg::OP_ACCEPT;
					state_d = ST_SIZE;
				end
			end
			ST_SIZE: begin
				op      = fhsr_pkg::OP_SIZE;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				op = fhsr_pkg::OP_CHECK;
				if (stat.idx_err) begin
					state_d = ST_FINAL;
				end else if (stat.no_sites) begin
					state_d = ST_DECIDE;
				end else begin
					state_d = ST_UNRANK;
				end
			end
			ST_UNRANK: begin
				op = fhsr_pkg::OP_UNRANK;
				if (stat.unrank_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				op      = fhsr_pkg::OP_DECIDE;
				state_d = stat.hop ? ST_RANK : ST_FINAL;
			end
			ST_RANK: begin
				op = fhsr_pkg::OP_RANK;
				if (stat.rank_last) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (!ov_q || result_ready) begin
					op      = fhsr_pkg::OP_OUTPUT;
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (result_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign item_ready   = state_q == ST_IDLE;
	assign result_valid = ov_q;

endmodule

// ----- sv/fermion_hop_sign_and_rank.sv -----
// ---------------------------------------------------------------------------
// fermion_hop_sign_and_rank
// Hopping term on a fixed-particle-number occupation basis: sign and index.
// ---------------------------------------------------------------------------
// Takes one operator word (source site, target site, basis index) at a time
// and returns one result word (sign, result index, index error).  The basis
// is every site_count-bit word with particle_count ones, ranked in
// descending order.  After reset the block builds its binomial table,
// (MAX_SITES + 1) * 32 entries (1024 at the default) with items.ready low;
// config writes are taken during that sweep.  Per word the table's single
// read port sets the pace: one lookup per site position (the site count
// clamped to MAX_SITES) in the unrank pass, then one per position in the
// rank pass.  A real hop runs both passes, a destroyed state or equal sites
// only the unrank pass, and an out-of-range index neither.  A new word can
// be accepted while the previous result still waits in the output register.
`include "fermion_hop_sign_and_rank_assert.svh"

module fermion_hop_sign_and_rank #(
	parameter int MAX_SITES = 31
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write port
	input  logic                              cfg_write,
	input  logic [fhsr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fhsr_pkg::SITE_W-1:0]       cfg_data,
	// operator words in, result words out
	fhsr_in_if.sink                           items,
	fhsr_out_if.source                        results
);

	fhsr_pkg::dp_op_t   op;
	fhsr_pkg::dp_stat_t stat;

	// sequencer: fill sweep, then per-word unrank, checks, rank, output
	fhsr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.stat         (stat),
		.item_valid   (items.valid),
		.item_ready   (items.ready),
		.result_valid (results.valid),
		.result_ready (results.ready),
		.op           (op)
	);

	// config registers, binomial table and the working registers
	fhsr_dp #(
		.MAX_SITES (MAX_SITES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op),
		.stat         (stat),
		.source_site  (items.source_site),
		.target_site  (items.target_site),
		.state_index  (items.state_index),
		.sign         (results.sign),
		.result_index (results.result_index),
		.index_error  (results.index_error)
	);

	// an out-of-range index never carries a sign or an index
	`FHSR_ASSERT_NOW(a_err_clean, results.valid && results.index_error, results.sign == fhsr_pkg::SIGN_ZERO && results.result_index == '0, "index error word with nonzero payload")
	// a destroyed state reports index zero
	`FHSR_ASSERT_NOW(a_zero_idx, results.valid && results.sign == fhsr_pkg::SIGN_ZERO, results.result_index == '0, "zero sign with nonzero index")
	// sign is one of the three legal codes
	`FHSR_ASSERT_NOW(a_sign_code, results.valid, results.sign == fhsr_pkg::SIGN_ZERO || results.sign == fhsr_pkg::SIGN_POS || results.sign == fhsr_pkg::SIGN_NEG, "illegal sign code")
	// one word in flight: ready drops right after an accept
	`FHSR_ASSERT_NEXT(a_one_word, items.valid && items.ready, !items.ready, "second word accepted back to back")

endmodule

// ----- test/fhsr_hop_checker.sv -----
// ---------------------------------------------------------------------------
// fhsr_hop_checker
// Watches the config port and both channels of the hopping block, works out
// the sign, result index and index error of every accepted operator word and
// compares them in order with the result words that come back.
// ---------------------------------------------------------------------------
module fhsr_hop_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [fhsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fhsr_pkg::SITE_W-1:0]    cfg_data,
	fhsr_in_if                             items,
	fhsr_out_if                            results,
	output int                             fail_count,
	output int                             words_pending,
	output logic [31:0]                    size_now,
	output int                             hops_moved,
	output int                             range_errors,
	output int                             words_checked
);

	localparam int MAX_SITES = 31;

	typedef struct packed {
		logic signed [1:0]           sign;
		logic [fhsr_pkg::BIN_W-1:0]  index;
		logic                        index_error;
	} hop_word_t;

	longint unsigned             pascal [0:31][0:31];
	hop_word_t                   hop_results_due [$];
	logic [fhsr_pkg::SITE_W-1:0] sites_cfg;
	logic [fhsr_pkg::SITE_W-1:0] particles_cfg;

	initial begin
		for (int n = 0; n < 32; n++)
			for (int k = 0; k < 32; k++)
				pascal[n][k] = (k == 0) ? 1 : (n == 0) ? 0 : pascal[n-1][k-1] + pascal[n-1][k];
	end

	function automatic longint unsigned choose(input int n, input int k);
		if (n < 0 || k > n)
			return 0;
		return pascal[n][k];
	endfunction

	// unrank, move one particle, rank back
	function automatic hop_word_t apply_hop(input logic [fhsr_pkg::SITE_W-1:0] src,
			input logic [fhsr_pkg::SITE_W-1:0] dst, input logic [fhsr_pkg::BIN_W-1:0] idx,
			input logic [fhsr_pkg::SITE_W-1:0] sc, input logic [fhsr_pkg::SITE_W-1:0] pc);
		int              s;
		int              p;
		int              k;
		int              parity;
		longint unsigned size;
		longint unsigned asc;
		logic [31:0]     occ;
		logic [31:0]     moved;
		hop_word_t       r;
		s = (int'(sc) > MAX_SITES) ? MAX_SITES : int'(sc);
		p = int'(pc);
		size = choose(s, p);
		r.sign = fhsr_pkg::SIGN_ZERO;
		r.index = '0;
		r.index_error = 1'b0;
		if (idx >= size) begin
			r.index_error = 1'b1;
			return r;
		end
		// greedy descent from the top site, rank counted from the smallest word
		asc = size - 1 - idx;
		occ = '0;
		k = p;
		for (int pos = s - 1; pos >= 0 && k > 0; pos--) begin
			if (choose(pos, k) <= asc) begin
				occ[pos] = 1'b1;
				asc -= choose(pos, k);
				k--;
			end
		end
		if (int'(src) >= s || !occ[src])
			return r;
		if (src == dst) begin
			r.sign = fhsr_pkg::SIGN_POS;
			r.index = idx;
			return r;
		end
		if (int'(dst) >= s || occ[dst])
			return r;
		moved = occ;
		moved[src] = 1'b0;
		moved[dst] = 1'b1;
		asc = 0;
		k = 0;
		for (int pos = 0; pos < s; pos++) begin
			if (moved[pos]) begin
				k++;
				asc += choose(pos, k);
			end
		end
		r.index = fhsr_pkg::BIN_W'(size - 1 - asc);
		parity = ((src < dst) ? 1 : 0) + $countones(occ & ((32'd1 << src) - 32'd1))
			+ $countones(occ & ((32'd1 << dst) - 32'd1));
		r.sign = parity[0] ? fhsr_pkg::SIGN_NEG : fhsr_pkg::SIGN_POS;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("mismatch at result word %0d: %s", words_checked, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		hop_word_t want;
		if (!arst_n) begin
			sites_cfg     <= fhsr_pkg::SITE_COUNT_RST;
			particles_cfg <= fhsr_pkg::PARTICLE_COUNT_RST;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					fhsr_pkg::CFG_SITE_COUNT:     sites_cfg <= cfg_data;
					fhsr_pkg::CFG_PARTICLE_COUNT: particles_cfg <= cfg_data;
					default: ;
				endcase
			end
			if (results.valid && results.ready) begin
				if (hop_results_due.size() == 0) begin
					report_mismatch("result word with nothing due");
				end else begin
					want = hop_results_due.pop_front();
					if (results.sign !== want.sign)
						report_mismatch($sformatf("sign %0d, want %0d",
							results.sign, want.sign));
					if (results.result_index !== want.index)
						report_mismatch($sformatf("result_index %0d, want %0d",
							results.result_index, want.index));
					if (results.index_error !== want.index_error)
						report_mismatch($sformatf("index_error %0b, want %0b",
							results.index_error, want.index_error));
					words_checked++;
				end
			end
			if (items.valid && items.ready) begin
				want = apply_hop(items.source_site, items.target_site, items.state_index,
					sites_cfg, particles_cfg);
				hop_results_due = {hop_results_due, want};
				if (want.index_error)
					range_errors++;
				else if (want.sign != fhsr_pkg::SIGN_ZERO
						&& items.source_site != items.target_site)
					hops_moved++;
			end
		end
		words_pending = hop_results_due.size();
		size_now = 32'(choose(int'(sites_cfg), int'(particles_cfg)));
	end

endmodule

// ----- test/tb_fermion_hop_sign_and_rank.sv -----
// ---------------------------------------------------------------------------
// tb_fermion_hop_sign_and_rank
// Drives operator words into the hopping block under a series of site and
// particle counts, stalls both channels at random and lets the checker
// compare every result word with its own prediction.
// ---------------------------------------------------------------------------
module tb_fermion_hop_sign_and_rank;

	localparam int LIMIT       = 1_000_000; // cycles, includes the table sweep after reset
	localparam int GAP_MAX     = 12;
	localparam int PHASE_WORDS = 83;
	localparam int NUM_PHASES  = 16;
	localparam int CFG_SETTLE  = 8;         // idle cycles before a register write
	localparam int TAIL_WAIT   = 150;       // wait for late or extra result words

	// register settings, one per random phase: extremes, empty bases, mid fillings
	int plan_sites     [NUM_PHASES] = '{31,  8, 31, 31, 1, 1, 0, 0, 5, 31, 31, 12, 20, 16, 2, 3};
	int plan_particles [NUM_PHASES] = '{15,  4,  0, 31, 1, 0, 0, 3, 7,  1, 30,  6, 10,  3, 1, 2};

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_write;
	logic [fhsr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [fhsr_pkg::SITE_W-1:0]    cfg_data;
	logic [31:0]                    size_now;
	int                             fail_count;
	int                             words_pending;
	int                             hops_moved;
	int                             range_errors;
	int                             words_checked;
	int                             words_sent;
	int                             ready_hold;
	int                             cycle_count;
	bit                             calm;         // no idling on either side while set

	fhsr_in_if  op_ch ();
	fhsr_out_if res_ch ();

	fermion_hop_sign_and_rank #(
		.MAX_SITES (31)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (op_ch),
		.results   (res_ch)
	);

	fhsr_hop_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.items         (op_ch),
		.results       (res_ch),
		.fail_count    (fail_count),
		.words_pending (words_pending),
		.size_now      (size_now),
		.hops_moved    (hops_moved),
		.range_errors  (range_errors),
		.words_checked (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: after each taken word hold ready low for a drawn number of cycles
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready)
			ready_hold <= calm ? 0 : $urandom_range(0, GAP_MAX);
		else if (ready_hold != 0)
			ready_hold <= ready_hold - 1;
	end

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready <= (ready_hold == 0);
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d words still due", cycle_count, words_pending);
		$display("== FAIL ==");
		$finish;
	end

	// one operator word: random gap, then hold valid until the block takes it
	task automatic send_word(input logic [fhsr_pkg::SITE_W-1:0] src,
			input logic [fhsr_pkg::SITE_W-1:0] dst, input logic [fhsr_pkg::BIN_W-1:0] idx);
		int gap;
		gap = calm ? 0 : $urandom_range(0, GAP_MAX);
		if (gap != 0) begin
			op_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		op_ch.valid       <= 1'b1;
		op_ch.source_site <= src;
		op_ch.target_site <= dst;
		op_ch.state_index <= idx;
		do @(posedge clk); while (!op_ch.ready);
		@(negedge clk);
		words_sent++;
	endtask

	// stop sending and wait for every result word, then a short settle
	task automatic drain_results();
		op_ch.valid <= 1'b0;
		while (words_pending != 0)
			@(negedge clk);
		repeat (CFG_SETTLE) @(negedge clk);
	endtask

	// both registers on back-to-back cycles, block idle
	task automatic write_settings(input int sites, input int parts);
		cfg_write <= 1'b1;
		cfg_index <= fhsr_pkg::CFG_SITE_COUNT;
		cfg_data  <= fhsr_pkg::SITE_W'(sites);
		@(negedge clk);
		cfg_index <= fhsr_pkg::CFG_PARTICLE_COUNT;
		cfg_data  <= fhsr_pkg::SITE_W'(parts);
		@(negedge clk);
		cfg_write <= 1'b0;
		// let the checker's basis size follow the new registers
		repeat (2) @(negedge clk);
	endtask

	// mostly sites inside the lattice, some anywhere in the 5-bit field
	function automatic logic [fhsr_pkg::SITE_W-1:0] pick_site(input int sites);
		if (sites > 0 && $urandom_range(0, 3) != 0)
			return fhsr_pkg::SITE_W'($urandom_range(0, sites - 1));
		return fhsr_pkg::SITE_W'($urandom_range(0, 31));
	endfunction

	// mostly valid ranks, with the edges of the basis and some out of range
	function automatic logic [fhsr_pkg::BIN_W-1:0] pick_index(input int unsigned size);
		int roll;
		roll = $urandom_range(0, 19);
		if (size == 0 || roll == 0)
			return fhsr_pkg::BIN_W'($urandom_range(size, 32'h1FFF_FFFF));
		if (roll == 1)
			return fhsr_pkg::BIN_W'(size);
		if (roll == 2)
			return fhsr_pkg::BIN_W'(size - 1);
		if (roll == 3)
			return '0;
		return fhsr_pkg::BIN_W'($urandom_range(0, size - 1));
	endfunction

	initial begin
		arst_n            = 1'b0;
		cfg_write         = 1'b0;
		cfg_index         = fhsr_pkg::CFG_SITE_COUNT;
		cfg_data          = '0;
		op_ch.valid       = 1'b0;
		op_ch.source_site = '0;
		op_ch.target_site = '0;
		op_ch.state_index = '0;
		calm              = 1'b0;
		words_sent        = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed words at the reset setting: 8 sites, 4 particles, 70 basis words
		// rank 0 is 11110000, rank 69 is 00001111
		send_word(5'd4, 5'd4, 29'd0);           // same site, occupied
		send_word(5'd0, 5'd0, 29'd0);           // same site, empty
		send_word(5'd7, 5'd0, 29'd0);           // top particle down to site 0
		send_word(5'd4, 5'd3, 29'd0);           // neighbor hop downward
		send_word(5'd0, 5'd5, 29'd0);           // empty source
		send_word(5'd5, 5'd6, 29'd0);           // occupied target
		send_word(5'd7, 5'd8, 29'd0);           // target past the last site
		send_word(5'd8, 5'd8, 29'd0);           // source past the last site
		send_word(5'd31, 5'd0, 29'd0);          // source at the top of the field
		send_word(5'd0, 5'd7, 29'd69);          // bottom particle to the top site
		send_word(5'd3, 5'd4, 29'd69);          // neighbor hop upward
		send_word(5'd3, 5'd31, 29'd69);         // target at the top of the field
		send_word(5'd5, 5'd2, 29'd69);          // empty source on the smallest word
		send_word(5'd2, 5'd5, 29'd35);
		send_word(5'd6, 5'd1, 29'd17);
		send_word(5'd1, 5'd30, 29'd40);
		send_word(5'd0, 5'd0, 29'd70);          // first rank out of range
		send_word(5'd31, 5'd31, 29'h1FFF_FFFF); // all ones, far out of range
		drain_results();

		// random phases, one register setting each
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			calm = (phase % 4 == 2);
			write_settings(plan_sites[phase], plan_particles[phase]);
			for (int n = 0; n < PHASE_WORDS; n++)
				send_word(pick_site(plan_sites[phase]), pick_site(plan_sites[phase]),
					pick_index(size_now));
			drain_results();
		end
		calm = 1'b0;

		// late or extra result words still get caught here
		repeat (TAIL_WAIT) @(negedge clk);

		$display("%0d operator words over the reset setting and %0d more register settings",
			words_sent, NUM_PHASES);
		$display("%0d results checked: %0d moved a particle, %0d had the index out of range",
			words_checked, hops_moved, range_errors);
		if (fail_count == 0 && words_pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d words never answered", fail_count, words_pending);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/fhsr_pkg.sv
sv/fhsr_if.sv
sv/fhsr_dp.sv
sv/fhsr_ctrl.sv
sv/fermion_hop_sign_and_rank.sv
test/fhsr_hop_checker.sv
test/tb_fermion_hop_sign_and_rank.sv
